// ----- rtl/iprl_pkg.sv -----
// ----------------------------------------------------------------------------
// iprl_pkg
// Shared types and constants for the IPv4 range table lookup core.
// ----------------------------------------------------------------------------
package iprl_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = 10;
    localparam int ADDR_W        = 32;
    localparam int LOC_W         = 32;
    localparam int ENTRY_W       = ADDR_W + LOC_W;
    localparam int GUARD_W       = 7;

    localparam logic [GUARD_W-1:0] GUARD_LIMIT = 7'd64;

    // tuser selector of an input transfer
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // configuration register indexes
    localparam logic CFG_FIRST_ENTRY = 1'b0;
    localparam logic CFG_LAST_ENTRY  = 1'b1;

    localparam logic [IDX_W-1:0] FIRST_ENTRY_RST = 10'd0;
    localparam logic [IDX_W-1:0] LAST_ENTRY_RST  = 10'd1023;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_RESP   = 3'b100
    } state_t;

endpackage

// ----- rtl/iprl_ram.sv -----
// ----------------------------------------------------------------------------
// iprl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iprl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ip_range_table_lookup_core.sv -----
// ----------------------------------------------------------------------------
// ip_range_table_lookup_core
// Range table of start address / location id pairs with binary search lookup.
// ----------------------------------------------------------------------------
// Load transfer: written in the accept cycle; the result is registered in ST_RESP.
// Lookup transfer: at most 11 probes for 1024 entries, one probe per cycle
//   through the registered table read and the compare, then ST_RESP.
// One item in flight; the next input is taken once the result is registered.
// rst_n clears control state and the bound registers; the table is undefined
// until loaded (no clearing pass).
// ----------------------------------------------------------------------------
module ip_range_table_lookup_core
    import iprl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [9:0]   cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index[9:0], entry_start_ip[41:10], entry_location[73:42],
    // ip_address[105:74], zero pad[111:106]
    input  logic [111:0] s_tdata,
    // mode[0]
    input  logic         s_tuser,
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // location_id[31:0], found_index[41:32], zero pad[47:42]
    output logic [47:0]  m_tdata
);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     first_entry_reg, last_entry_reg;
    logic [IDX_W-1:0]     lo_reg, lo_next;
    logic [IDX_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     probe_reg, probe_next;
    logic [GUARD_W-1:0]   guard_reg, guard_next;
    logic [ADDR_W-1:0]    ip_reg;
    logic                 lookup_reg;
    logic                 m_tvalid_reg;
    logic [47:0]          m_tdata_reg;

    logic                 accept;
    logic                 out_free;
    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [IDX_W-1:0]     spread;
    logic                 probe_gt;
    logic                 search_more;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign ram_we   = accept && (s_tuser == MODE_LOAD);

    // entry word: start address low, location id high
    iprl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s_tdata[9:0]),
        .wdata ({s_tdata[73:42], s_tdata[41:10]}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one probe step: move a bound, then the next probe is lo + spread/2 (wrapping)
    always_comb
    begin
        probe_gt    = ram_rdata[ADDR_W-1:0] > ip_reg;
        lo_next     = probe_gt ? lo_reg : probe_reg;
        hi_next     = probe_gt ? probe_reg : hi_reg;
        spread      = hi_next - lo_next;
        probe_next  = lo_next + {1'b0, spread[IDX_W-1:1]};
        guard_next  = guard_reg + 7'd1;
        search_more = (lo_next < probe_next) && (guard_next < GUARD_LIMIT);
    end

    always_comb
    begin
        state_next = state_reg;
        ram_re     = 1'b0;
        ram_raddr  = probe_next;
        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = last_entry_reg;
                if (accept)
                begin
                    ram_re     = (s_tuser == MODE_LOOKUP);
                    state_next = (s_tuser == MODE_LOOKUP) ? ST_SEARCH : ST_RESP;
                end
            end
            ST_SEARCH:
            begin
                // the last read also fetches the entry that is returned
                ram_re = 1'b1;
                if (!search_more)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            first_entry_reg <= FIRST_ENTRY_RST;
            last_entry_reg  <= LAST_ENTRY_RST;
            m_tvalid_reg    <= 1'b0;
            guard_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_ENTRY: first_entry_reg <= cfg_wdata;
                    CFG_LAST_ENTRY:  last_entry_reg  <= cfg_wdata;
                    default:         last_entry_reg  <= last_entry_reg;
                endcase
            end
            if (accept)
            begin
                guard_reg <= '0;
            end
            else if (state_reg == ST_SEARCH)
            begin
                guard_reg <= guard_next;
            end
            if ((state_reg == ST_RESP) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg     <= first_entry_reg;
            hi_reg     <= last_entry_reg;
            probe_reg  <= last_entry_reg;
            ip_reg     <= s_tdata[105:74];
            lookup_reg <= (s_tuser == MODE_LOOKUP);
        end
        else if (state_reg == ST_SEARCH)
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            probe_reg <= probe_next;
        end
        if ((state_reg == ST_RESP) && out_free)
        begin
            if (lookup_reg)
            begin
                m_tdata_reg <= {6'd0, probe_reg, ram_rdata[ENTRY_W-1:ADDR_W]};
            end
            else
            begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // table is only written between searches
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("table write outside idle");

    // a lookup transfer starts a search
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == MODE_LOOKUP)) |=> (state_reg == ST_SEARCH))
        else $error("lookup did not start a search");

    // the search always ends within the probe limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (guard_reg < GUARD_LIMIT))
        else $error("search ran past the probe limit");

    // a new result only comes from the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_RESP))
        else $error("result raised outside the response state");

endmodule
